// ===== rtl/core/sinc_rs_pkg.sv =====
// shared types, constants and the sinc coefficient table of the resampler
// no dependencies; imported by every module of the block

package sinc_rs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int STEP_W     = 21;
    localparam int PHASE_W    = 22;
    localparam int PHASE_FRAC = 16;
    localparam int TAPS       = 5;
    localparam int PHASES     = 16;
    localparam int ROW_W      = $clog2(PHASES);
    localparam int MAX_OUT    = 16;
    localparam int CNT_W      = $clog2(MAX_OUT);
    localparam int ONE_Q16    = 65536;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + $clog2(TAPS);
    localparam int RND_SHIFT  = 14;
    localparam int RND_BIAS   = 8192;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [PHASE_W-1:0]  phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic             launch;
        logic [ROW_W-1:0] row;
        logic             load;
        logic             last;
    } seq_ctl_t;

    // truncated sinc, Q2.14; row = fractional phase, column 0 = oldest sample
    localparam coef_t COEF_ROM [PHASES][TAPS] = '{
        '{16'sd0,    16'sd0,     16'sd16384, 16'sd0,     16'sd0    },
        '{16'sd493,  -16'sd958,  16'sd16279, 16'sd1085,  -16'sd525 },
        '{16'sd939,  -16'sd1774, 16'sd15966, 16'sd2281,  -16'sd1064},
        '{16'sd1325, -16'sd2440, 16'sd15453, 16'sd3566,  -16'sd1599},
        '{16'sd1639, -16'sd2950, 16'sd14751, 16'sd4917,  -16'sd2107},
        '{16'sd1875, -16'sd3304, 16'sd13876, 16'sd6307,  -16'sd2570},
        '{16'sd2029, -16'sd3504, 16'sd12849, 16'sd7709,  -16'sd2965},
        '{16'sd2098, -16'sd3558, 16'sd11691, 16'sd9093,  -16'sd3274},
        '{16'sd2086, -16'sd3477, 16'sd10430, 16'sd10430, -16'sd3477},
        '{16'sd1996, -16'sd3274, 16'sd9093,  16'sd11691, -16'sd3558},
        '{16'sd1836, -16'sd2965, 16'sd7709,  16'sd12849, -16'sd3504},
        '{16'sd1613, -16'sd2570, 16'sd6307,  16'sd13876, -16'sd3304},
        '{16'sd1341, -16'sd2107, 16'sd4917,  16'sd14751, -16'sd2950},
        '{16'sd1030, -16'sd1599, 16'sd3566,  16'sd15453, -16'sd2440},
        '{16'sd694,  -16'sd1064, 16'sd2281,  16'sd15966, -16'sd1774},
        '{16'sd346,  -16'sd525,  16'sd1085,  16'sd16279, -16'sd958 }
    };

endpackage

// ===== rtl/core/sinc_interpolation_resampler_unit.sv =====
// truncated-sinc resampler top level: cell row, sequencer, rounding, output register
// an input goes through check, launch, one multiply-accumulate cell per tap and emit
// before its first output is valid; each further output repeats launch, cells and emit;
// stalls hold emit; a new input waits for all N outputs (N up to 16), or the check if none
// reset (rst_n low, async): history zero, phase 1.0, phase_step 1.0, output empty
// depends on sinc_rs_pkg, sinc_rs_cell, sinc_rs_ctrl

module sinc_interpolation_resampler_unit
    import sinc_rs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data,     // phase_step
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,    // [15:0] in_sample
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,    // [15:0] out_sample
    output logic              m_axis_tlast     // run_last
);

    localparam int RQ_W = ACC_W + 1 - RND_SHIFT;
    localparam logic signed [RQ_W-1:0] SAT_HI = RQ_W'(2**(SAMPLE_W-1) - 1);
    localparam logic signed [RQ_W-1:0] SAT_LO = RQ_W'(-(2**(SAMPLE_W-1)));

    seq_ctl_t   ctl;
    logic       in_ready;
    logic       in_fire;
    logic       out_free;

    sample_t    hist [TAPS];
    logic       tok  [TAPS+1];
    acc_t       psum [TAPS+1];

    logic signed [ACC_W:0]    biased;
    logic signed [RQ_W-1:0]   rq;
    sample_t                  rounded;

    logic       out_valid_reg;
    logic       out_valid_next;
    sample_t    out_data_reg;
    logic       out_last_reg;

    assign in_fire       = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    sinc_rs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .chain_done  (tok[TAPS]),
        .out_free    (out_free),
        .in_ready    (in_ready),
        .ctl         (ctl)
    );

    assign tok[0]  = ctl.launch;
    assign psum[0] = '0;

    // history shifts toward cell 0 (oldest), partial sums run toward the last cell
    for (genvar i = 0; i < TAPS; i++)
    begin : g_cell
        sample_t s_in;
        if (i == TAPS - 1)
        begin : g_head
            assign s_in = sample_t'(s_axis_tdata);
        end
        else
        begin : g_body
            assign s_in = hist[i+1];
        end

        sinc_rs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (in_fire),
            .sample_in  (s_in),
            .sample_out (hist[i]),
            .coef       (COEF_ROM[ctl.row][i]),
            .valid_in   (tok[i]),
            .psum_in    (psum[i]),
            .valid_out  (tok[i+1]),
            .psum_out   (psum[i+1])
        );
    end

    // round half up by floor((acc + bias) / 2^14), then saturate
    always_comb
    begin
        biased = $signed({psum[TAPS][ACC_W-1], psum[TAPS]}) + (ACC_W+1)'(RND_BIAS);
        rq     = biased[ACC_W:RND_SHIFT];
        if (rq > SAT_HI)
            rounded = SAT_HI[SAMPLE_W-1:0];
        else if (rq < SAT_LO)
            rounded = SAT_LO[SAMPLE_W-1:0];
        else
            rounded = rq[SAMPLE_W-1:0];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            out_data_reg <= rounded;
            out_last_reg <= ctl.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/core/sinc_rs_cell.sv =====
// one cell of the filter row: holds one history sample, adds its product
// to the partial sum passing through; depends on sinc_rs_pkg

module sinc_rs_cell
    import sinc_rs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift_en,
    input  sample_t sample_in,
    output sample_t sample_out,
    input  coef_t   coef,
    input  logic    valid_in,
    input  acc_t    psum_in,
    output logic    valid_out,
    output acc_t    psum_out
);

    sample_t                    sample_reg;
    sample_t                    sample_next;
    logic                       valid_reg;
    acc_t                       psum_reg;
    acc_t                       psum_next;
    logic signed [PROD_W-1:0]   prod;

    always_comb
    begin
        sample_next = shift_en ? sample_in : sample_reg;
        prod        = sample_reg * coef;
        psum_next   = psum_in + acc_t'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            sample_reg <= sample_next;
            valid_reg  <= valid_in;
        end
    end

    // partial sum only moves with its token, so the last cell holds the result
    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            psum_reg <= psum_next;
        end
    end

    assign sample_out = sample_reg;
    assign valid_out  = valid_reg;
    assign psum_out   = psum_reg;

endmodule

// ===== rtl/core/sinc_rs_ctrl.sv =====
// sequencer of the resampler: phase accumulator, step register, output count
// depends on sinc_rs_pkg

module sinc_rs_ctrl
    import sinc_rs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data,
    input  logic              in_fire,
    input  logic              chain_done,
    input  logic              out_free,
    output logic              in_ready,
    output seq_ctl_t          ctl
);

    localparam logic signed [PHASE_W:0] ONE_X = (PHASE_W+1)'(ONE_Q16);
    localparam logic signed [PHASE_W:0] LO_X  = (PHASE_W+1)'(-(2**(PHASE_W-1)));
    localparam logic signed [PHASE_W:0] HI_X  = (PHASE_W+1)'(2**(PHASE_W-1) - 1);
    localparam phase_t                  ONE_P = PHASE_W'(ONE_Q16);

    seq_state_t             state_reg;
    seq_state_t             state_next;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic signed [PHASE_W:0] dec_wide;
    logic signed [PHASE_W:0] inc_wide;
    phase_t                  phase_dec;
    phase_t                  phase_inc;
    logic                    has_work;
    logic                    is_last;
    logic [ROW_W-1:0]        row;

    always_comb
    begin
        dec_wide = $signed({phase_reg[PHASE_W-1], phase_reg}) - ONE_X;
        inc_wide = $signed({phase_reg[PHASE_W-1], phase_reg})
                   + $signed({2'b00, step_reg});
        phase_dec = (dec_wide < LO_X) ? LO_X[PHASE_W-1:0] : dec_wide[PHASE_W-1:0];
        phase_inc = (inc_wide > HI_X) ? HI_X[PHASE_W-1:0] : inc_wide[PHASE_W-1:0];
        has_work  = (phase_reg < ONE_P);
        // negative or zero phase uses the first row
        row       = (phase_reg > 0) ? phase_reg[PHASE_FRAC-1 -: ROW_W] : '0;
        is_last   = (count_reg == CNT_W'(MAX_OUT - 1)) || (phase_inc >= ONE_P);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = has_work ? S_RUN : S_IDLE;
            end
            S_RUN:
            begin
                if (chain_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = is_last ? S_IDLE : S_CHECK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // phase, count and step updates
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        step_next  = cfg_wr_en ? cfg_wr_data : step_reg;
        if (state_reg == S_IDLE && in_fire)
        begin
            phase_next = phase_dec;
            count_next = '0;
        end
        else if (state_reg == S_EMIT && out_free)
        begin
            phase_next = phase_inc;
            count_next = count_reg + 1'b1;
        end
    end

    // outputs
    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        ctl.launch = (state_reg == S_CHECK) && has_work;
        ctl.row    = row;
        ctl.load   = (state_reg == S_EMIT) && out_free;
        ctl.last   = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= ONE_P;
            step_reg  <= STEP_W'(ONE_Q16);
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/sinc_rs_chk.sv =====
// port-level checks on the resampler top level, attached with bind
// depends on sinc_rs_pkg and sinc_interpolation_resampler_unit

module sinc_rs_chk
    import sinc_rs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [15:0]       m_axis_tdata,
    input logic              m_axis_tlast
);

    // a stalled output request keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    // one input at a time: ready drops right after a request is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // a run is not finished while a non-final output is pending
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready before the run ended");

    // nothing comes out in the cycle right after an input is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("output appeared too early");

endmodule

bind sinc_interpolation_resampler_unit sinc_rs_chk u_sinc_rs_chk (.*);
